// ===== hw/rtl/silb_pkg.sv =====
package silb_pkg;

    localparam int SERVICES      = 16;
    localparam int MAX_INSTANCES = 8;
    localparam int CLIENTS       = 64;

    localparam int SVC_W   = (SERVICES > 1) ? $clog2(SERVICES) : 1;
    localparam int INST_W  = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CLI_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_INSTANCES + 1);
    localparam int FILL_W  = $clog2(CLIENTS + 1);
    localparam int IDX_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int IDEPTH  = SERVICES * MAX_INSTANCES;
    localparam int IADDR_W = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

    localparam logic [15:0] LOAD_MAX = 16'hFFFF;

    localparam logic [1:0] POL_STATIC = 2'd0;
    localparam logic [1:0] POL_RR     = 2'd1;

    localparam logic [2:0] ST_SAME  = 3'd0;
    localparam logic [2:0] ST_SET   = 3'd1;
    localparam logic [2:0] ST_AFULL = 3'd2;
    localparam logic [2:0] ST_NONE  = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_IFULL = 3'd6;

    localparam logic [2:0] EM_NONE = 3'd0;
    localparam logic [2:0] EM_DEC  = 3'd1;
    localparam logic [2:0] EM_BUMP = 3'd2;
    localparam logic [2:0] EM_FIN  = 3'd3;
    localparam logic [2:0] EM_APP  = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  service;
        logic [31:0] client_addr;
        logic [31:0] instance_addr;
        logic [31:0] public_addr;
        logic [7:0]  tie_bits;
    } in_t;

    typedef struct packed {
        logic [31:0] server_addr;
        logic [31:0] public_out;
        logic [15:0] load_after;
        logic [2:0]  status;
    } out_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] load;
        logic [31:0] pub;
    } inst_ent_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] server;
    } cli_ent_t;

    typedef struct packed {
        logic             load;
        logic             rd_k;
        logic             cap_inst;
        logic             cap_k;
        logic             cap_cli;
        logic             cli_clr;
        logic             min_clr;
        logic             min_upd;
        logic             rr_upd;
        logic             emit;
        logic [2:0]       emit_kind;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] pidx;
    } ctl_t;

    typedef struct packed {
        logic              is_update;
        logic [1:0]        policy;
        logic [CNT_W-1:0]  n;
        logic [FILL_W-1:0] fill;
        logic              ihit;
        logic              chit;
        logic              have;
        logic              rr_ok;
    } sts_t;

endpackage

// ===== hw/rtl/silb_ram.sv =====
module silb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/silb_ctrl.sv =====
module silb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  silb_pkg::sts_t     sts,
    output silb_pkg::ctl_t     ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_ISCAN  = 4'd2;
    localparam logic [3:0] S_CSCAN1 = 4'd3;
    localparam logic [3:0] S_MIN    = 4'd4;
    localparam logic [3:0] S_RR     = 4'd5;
    localparam logic [3:0] S_KRD    = 4'd6;
    localparam logic [3:0] S_KWT    = 4'd7;
    localparam logic [3:0] S_CSCAN2 = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]                 state_reg, state_next;
    logic [silb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [silb_pkg::IDX_W-1:0] pidx_reg, pidx_next;
    logic                       pend_reg, pend_next;
    logic [2:0]                 ekind_reg, ekind_next;
    logic [silb_pkg::IDX_W-1:0] limit;
    logic                       issue;
    logic                       scan_end;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        limit = (state_reg == S_CSCAN1 || state_reg == S_CSCAN2)
              ? silb_pkg::IDX_W'(sts.fill) : silb_pkg::IDX_W'(sts.n);
        issue    = (idx_reg < limit);
        scan_end = !pend_reg && !issue;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = issue ? idx_reg + 1'b1 : idx_reg;
        pend_next  = issue;
        pidx_next  = idx_reg;
        ekind_next = ekind_reg;
        ctl        = '0;
        ctl.idx    = idx_reg;
        ctl.pidx   = pidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ctl.cli_clr = 1'b1;
                if (sts.is_update)
                begin
                    state_next = S_ISCAN;
                end
                else if (sts.policy == silb_pkg::POL_STATIC)
                begin
                    state_next = S_CSCAN1;
                end
                else if (sts.policy == silb_pkg::POL_RR)
                begin
                    state_next = S_RR;
                end
                else
                begin
                    ctl.min_clr = 1'b1;
                    state_next  = S_MIN;
                end
            end
            S_ISCAN:
            begin
                if (pend_reg && sts.ihit)
                begin
                    ctl.cap_inst = 1'b1;
                    ctl.cap_k    = 1'b1;
                    ekind_next   = sts.is_update ? silb_pkg::EM_DEC : silb_pkg::EM_BUMP;
                    state_next   = S_EMIT;
                end
                else if (scan_end)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = sts.is_update ? silb_pkg::EM_APP : silb_pkg::EM_NONE;
                    state_next    = S_IDLE;
                end
            end
            S_CSCAN1:
            begin
                if (pend_reg && sts.chit)
                begin
                    ctl.cap_cli = 1'b1;
                    state_next  = S_ISCAN;
                end
                else if (scan_end)
                begin
                    ctl.min_clr = 1'b1;
                    state_next  = S_MIN;
                end
            end
            S_MIN:
            begin
                ctl.min_upd = pend_reg;
                if (scan_end)
                begin
                    if (sts.have)
                    begin
                        state_next = S_KRD;
                    end
                    else
                    begin
                        ctl.emit      = 1'b1;
                        ctl.emit_kind = silb_pkg::EM_NONE;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_RR:
            begin
                ctl.rr_upd = 1'b1;
                if (sts.rr_ok)
                begin
                    state_next = S_KRD;
                end
                else
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = silb_pkg::EM_NONE;
                    state_next    = S_IDLE;
                end
            end
            S_KRD:
            begin
                ctl.rd_k   = 1'b1;
                state_next = S_KWT;
            end
            S_KWT:
            begin
                ctl.cap_inst = 1'b1;
                state_next   = S_CSCAN2;
            end
            S_CSCAN2:
            begin
                if (pend_reg && sts.chit)
                begin
                    ctl.cap_cli = 1'b1;
                    ekind_next  = silb_pkg::EM_FIN;
                    state_next  = S_EMIT;
                end
                else if (scan_end)
                begin
                    ekind_next = silb_pkg::EM_FIN;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_kind = ekind_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next != state_reg)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        ekind_reg <= ekind_next;
    end

endmodule

// ===== hw/rtl/silb_dp.sv =====
module silb_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  silb_pkg::in_t  item,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_data,
    input  silb_pkg::ctl_t ctl,
    output silb_pkg::sts_t sts,
    output silb_pkg::out_t result,
    output logic           result_valid
);

    silb_pkg::in_t              in_reg;
    logic [1:0]                 policy_reg;
    logic [silb_pkg::CNT_W-1:0] count_reg [silb_pkg::SERVICES];
    logic [silb_pkg::INST_W-1:0] rrpos_reg [silb_pkg::SERVICES];
    logic [silb_pkg::SERVICES-1:0] rrseen_reg;
    logic [silb_pkg::FILL_W-1:0] fill_reg;
    silb_pkg::inst_ent_t        ent_reg;
    logic [silb_pkg::INST_W-1:0] k_reg;
    logic [15:0]                best_reg;
    logic                       have_reg;
    logic                       cfound_reg;
    logic [silb_pkg::CLI_W-1:0] cidx_reg;
    logic [31:0]                srv_reg;
    silb_pkg::out_t             out_reg, out_next;
    logic                       valid_reg;

    logic [silb_pkg::SVC_W-1:0]  svc;
    logic [silb_pkg::CNT_W-1:0]  n;
    logic [silb_pkg::IADDR_W-1:0] base;
    logic [silb_pkg::INST_W-1:0] ridx;
    logic [silb_pkg::CNT_W-1:0]  rr_inc, rr_new;
    logic                        take;
    logic [15:0]                 bump_load, dec_load;
    logic                        app_ok;

    silb_pkg::inst_ent_t          irdata, iwdata;
    logic                         iwe;
    logic [silb_pkg::IADDR_W-1:0] iwaddr;
    silb_pkg::cli_ent_t           crdata, cwdata;
    logic                         cwe;
    logic [silb_pkg::CLI_W-1:0]   cwaddr;
    logic                         count_inc, fill_inc;

    always_comb
    begin
        svc  = in_reg.service[silb_pkg::SVC_W-1:0];
        n    = count_reg[svc];
        base = silb_pkg::IADDR_W'(silb_pkg::IADDR_W'(svc)
             * silb_pkg::IADDR_W'(silb_pkg::MAX_INSTANCES));
        ridx = ctl.rd_k ? k_reg : ctl.idx[silb_pkg::INST_W-1:0];
        rr_inc = rrseen_reg[svc] ? silb_pkg::CNT_W'(rrpos_reg[svc]) + 1'b1 : '0;
        rr_new = (rr_inc >= n) ? '0 : rr_inc;
        take = !have_reg || (irdata.load < best_reg)
            || (irdata.load == best_reg && !in_reg.tie_bits[ctl.pidx[2:0]]);
        bump_load = (ent_reg.load == silb_pkg::LOAD_MAX) ? ent_reg.load : ent_reg.load + 16'd1;
        dec_load  = (ent_reg.load != 16'd0) ? ent_reg.load - 16'd1 : ent_reg.load;
        app_ok    = (n < silb_pkg::CNT_W'(silb_pkg::MAX_INSTANCES));
    end

    always_comb
    begin
        sts.is_update = in_reg.cmd;
        sts.policy    = policy_reg;
        sts.n         = n;
        sts.fill      = fill_reg;
        sts.ihit      = (irdata.addr == (in_reg.cmd ? in_reg.instance_addr : srv_reg));
        sts.chit      = (crdata.addr == in_reg.client_addr);
        sts.have      = have_reg;
        sts.rr_ok     = (rr_new < n);
    end

    always_comb
    begin
        out_next  = '0;
        iwe       = 1'b0;
        iwaddr    = base + silb_pkg::IADDR_W'(k_reg);
        iwdata    = ent_reg;
        cwe       = 1'b0;
        cwaddr    = cidx_reg;
        cwdata.addr   = in_reg.client_addr;
        cwdata.server = ent_reg.addr;
        count_inc = 1'b0;
        fill_inc  = 1'b0;
        out_next.status = silb_pkg::ST_NONE;
        unique case (ctl.emit_kind)
            silb_pkg::EM_DEC:
            begin
                iwe         = ctl.emit;
                iwdata.load = dec_load;
                out_next    = '{ent_reg.addr, ent_reg.pub, dec_load, silb_pkg::ST_DEC};
            end
            silb_pkg::EM_BUMP:
            begin
                iwe         = ctl.emit;
                iwdata.load = bump_load;
                out_next    = '{ent_reg.addr, ent_reg.pub, bump_load, silb_pkg::ST_SAME};
            end
            silb_pkg::EM_FIN:
            begin
                iwe         = ctl.emit;
                iwdata.load = bump_load;
                out_next    = '{ent_reg.addr, ent_reg.pub, bump_load, silb_pkg::ST_AFULL};
                if (cfound_reg)
                begin
                    cwe = ctl.emit;
                    out_next.status = (srv_reg == ent_reg.addr) ? silb_pkg::ST_SAME
                                                                : silb_pkg::ST_SET;
                end
                else if (fill_reg < silb_pkg::FILL_W'(silb_pkg::CLIENTS))
                begin
                    cwe      = ctl.emit;
                    cwaddr   = fill_reg[silb_pkg::CLI_W-1:0];
                    fill_inc = ctl.emit;
                    out_next.status = silb_pkg::ST_SET;
                end
            end
            silb_pkg::EM_APP:
            begin
                if (app_ok)
                begin
                    iwe       = ctl.emit;
                    iwaddr    = base + silb_pkg::IADDR_W'(n);
                    iwdata    = '{in_reg.instance_addr, 16'd0, in_reg.public_addr};
                    count_inc = ctl.emit;
                    out_next  = '{in_reg.instance_addr, in_reg.public_addr, 16'd0,
                                  silb_pkg::ST_ADD};
                end
                else
                begin
                    out_next.status = silb_pkg::ST_IFULL;
                end
            end
            default:
            begin
                out_next.status = silb_pkg::ST_NONE;
            end
        endcase
    end

    silb_ram #(
        .WIDTH($bits(silb_pkg::inst_ent_t)),
        .DEPTH(silb_pkg::IDEPTH)
    ) u_inst_ram (
        .clk   (clk),
        .we    (iwe),
        .waddr (iwaddr),
        .wdata (iwdata),
        .raddr (base + silb_pkg::IADDR_W'(ridx)),
        .rdata (irdata)
    );

    silb_ram #(
        .WIDTH($bits(silb_pkg::cli_ent_t)),
        .DEPTH(silb_pkg::CLIENTS)
    ) u_cli_ram (
        .clk   (clk),
        .we    (cwe),
        .waddr (cwaddr),
        .wdata (cwdata),
        .raddr (ctl.idx[silb_pkg::CLI_W-1:0]),
        .rdata (crdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 2'd2;
            fill_reg   <= '0;
            rrseen_reg <= '0;
            valid_reg  <= 1'b0;
            for (int i = 0; i < silb_pkg::SERVICES; i++)
            begin
                count_reg[i] <= '0;
                rrpos_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= ctl.emit;
            if (cfg_valid)
            begin
                policy_reg <= cfg_data;
            end
            if (fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (count_inc)
            begin
                count_reg[svc] <= n + 1'b1;
            end
            if (ctl.rr_upd)
            begin
                rrseen_reg[svc] <= 1'b1;
                rrpos_reg[svc]  <= rr_new[silb_pkg::INST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= item;
        end
        if (ctl.emit)
        begin
            out_reg <= out_next;
        end
        if (ctl.cap_inst)
        begin
            ent_reg <= irdata;
        end
        if (ctl.cap_k)
        begin
            k_reg <= ctl.pidx[silb_pkg::INST_W-1:0];
        end
        if (ctl.cli_clr)
        begin
            cfound_reg <= 1'b0;
        end
        else if (ctl.cap_cli)
        begin
            cfound_reg <= 1'b1;
            cidx_reg   <= ctl.pidx[silb_pkg::CLI_W-1:0];
            srv_reg    <= crdata.server;
        end
        if (ctl.min_clr)
        begin
            have_reg <= 1'b0;
            best_reg <= '0;
        end
        else if (ctl.min_upd && take)
        begin
            have_reg <= 1'b1;
            best_reg <= irdata.load;
            k_reg    <= ctl.pidx[silb_pkg::INST_W-1:0];
        end
        else if (ctl.rr_upd)
        begin
            have_reg <= (rr_new < n);
            k_reg    <= rr_new[silb_pkg::INST_W-1:0];
        end
    end

    assign result       = out_reg;
    assign result_valid = valid_reg;

endmodule

// ===== hw/rtl/server_instance_load_balancer_top.sv =====
// One request at a time: busy stays high from the accepting edge until the result is ready.
// An update scans the service's n instances; a request scans up to n instances and its fill clients up to twice.
// Scans of the instance and affinity memories run at one read per cycle.
// result_valid pulses for one cycle; a new request may start in that same cycle.
// Reset clears counts, round-robin state, affinity fill and sets policy to shortest queue.
module server_instance_load_balancer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  silb_pkg::in_t  item,
    output silb_pkg::out_t result,
    output logic           result_valid,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_data
);

    silb_pkg::ctl_t ctl;
    silb_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    silb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    silb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== test/tb.sv =====
module tb;
    import silb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] POL_SHORTEST = 2'd2;
    localparam logic [1:0] POL_SPARE    = 2'd3;
    localparam logic       CMD_REQUEST  = 1'b0;
    localparam logic       CMD_UPDATE   = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  item = '0;
    out_t result;
    logic result_valid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = '0;

    server_instance_load_balancer_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result(result), .result_valid(result_valid),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // balancer predictor state
    logic [1:0]  pol_m;
    int unsigned cnt_m [SERVICES];
    logic [31:0] iaddr_m [SERVICES*MAX_INSTANCES];
    logic [15:0] iload_m [SERVICES*MAX_INSTANCES];
    logic [31:0] ipub_m [SERVICES*MAX_INSTANCES];
    int unsigned rrpos_m [SERVICES];
    bit          rrseen_m [SERVICES];
    int unsigned fill_m;
    logic [31:0] caddr_m [CLIENTS];
    logic [31:0] csrv_m [CLIENTS];

    out_t        pending_q [$];
    bit          failed = 1'b0;
    int          idle_pct = 0;
    int unsigned quiet = 0;
    logic [31:0] addr_pool [16];
    logic [31:0] client_pool [80];

    function automatic int find_cli(logic [31:0] a);
        for (int i = 0; i < fill_m; i++)
            if (caddr_m[i] == a) return i;
        return CLIENTS;
    endfunction

    function automatic int find_inst(int b, int n, logic [31:0] a);
        for (int i = 0; i < n; i++)
            if (iaddr_m[b+i] == a) return i;
        return n;
    endfunction

    function automatic out_t mk(logic [31:0] s, logic [31:0] p, logic [15:0] l,
                                logic [2:0] st);
        out_t o;
        o.server_addr = s; o.public_out = p; o.load_after = l; o.status = st;
        return o;
    endfunction

    function automatic out_t balance(in_t x);
        int s, b, n, k, c, slot, pos;
        logic [1:0] pol;
        bit have;
        logic [15:0] best;
        logic [31:0] a;
        logic [2:0] st;
        s = x.service; b = s * MAX_INSTANCES; n = cnt_m[s]; pol = pol_m;
        have = 1'b0; k = 0; best = '0;
        if (x.cmd == CMD_UPDATE) begin
            k = find_inst(b, n, x.instance_addr);
            if (k < n) begin
                if (iload_m[b+k] > 0) iload_m[b+k]--;
                return mk(x.instance_addr, ipub_m[b+k], iload_m[b+k], ST_DEC);
            end
            if (n < MAX_INSTANCES) begin
                iaddr_m[b+n] = x.instance_addr; iload_m[b+n] = '0;
                ipub_m[b+n] = x.public_addr; cnt_m[s] = n + 1;
                return mk(x.instance_addr, x.public_addr, '0, ST_ADD);
            end
            return mk('0, '0, '0, ST_IFULL);
        end
        if (pol == POL_STATIC) begin
            c = find_cli(x.client_addr);
            if (c < CLIENTS) begin
                k = find_inst(b, n, csrv_m[c]);
                if (k < n) begin
                    if (iload_m[b+k] != LOAD_MAX) iload_m[b+k]++;
                    return mk(iaddr_m[b+k], ipub_m[b+k], iload_m[b+k], ST_SAME);
                end
                return mk('0, '0, '0, ST_NONE);
            end
            pol = POL_SHORTEST;
        end
        if (pol == POL_RR) begin
            pos = 0;
            if (rrseen_m[s]) begin
                pos = rrpos_m[s] + 1;
                if (pos >= n) pos = 0;
            end
            rrseen_m[s] = 1'b1; rrpos_m[s] = pos;
            if (pos < n) begin k = pos; have = 1'b1; end
        end else begin
            for (int i = 0; i < n; i++)
                if (!have || iload_m[b+i] < best ||
                    (iload_m[b+i] == best && !x.tie_bits[i%8])) begin
                    k = i; best = iload_m[b+i]; have = 1'b1;
                end
        end
        if (!have) return mk('0, '0, '0, ST_NONE);
        slot = b + k; a = iaddr_m[slot];
        c = find_cli(x.client_addr);
        if (c < CLIENTS) begin
            st = (csrv_m[c] == a) ? ST_SAME : ST_SET;
            csrv_m[c] = a;
        end else if (fill_m < CLIENTS) begin
            caddr_m[fill_m] = x.client_addr; csrv_m[fill_m] = a; fill_m++;
            st = ST_SET;
        end else st = ST_AFULL;
        if (iload_m[slot] != LOAD_MAX) iload_m[slot]++;
        return mk(a, ipub_m[slot], iload_m[slot], st);
    endfunction

    task automatic send_request(in_t x);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= x;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q = {pending_q, balance(x)};
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pol_m = p;
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t rand_item(bit upd, int svc);
        in_t x;
        x.cmd = upd;
        x.service = 4'(svc);
        x.client_addr = ($urandom_range(9) == 0) ? $urandom() : client_pool[$urandom_range(79)];
        x.instance_addr = ($urandom_range(15) == 0) ? $urandom() : addr_pool[$urandom_range(15)];
        x.public_addr = $urandom();
        x.tie_bits = 8'($urandom());
        return x;
    endfunction

    task automatic test_directed();
        in_t x;
        x = '0;
        x.cmd = CMD_REQUEST; x.service = 4'd15; send_request(x);
        x.cmd = CMD_UPDATE; x.instance_addr = 32'hFFFF_FFFF; x.public_addr = 32'hFFFF_FFFF;
        send_request(x);
        x.instance_addr = '0; x.public_addr = '0; send_request(x);
        for (int i = 0; i < 7; i++) begin
            x.instance_addr = 32'h0A00_0001 + i; x.public_addr = 32'hC000_0000 + i;
            send_request(x);
        end
        x.instance_addr = 32'h0B00_0000; send_request(x);
        x.instance_addr = 32'hFFFF_FFFF; send_request(x);
        x.instance_addr = '0; send_request(x);
        x.cmd = CMD_REQUEST; x.client_addr = 32'hFFFF_FFFF; x.tie_bits = 8'hFF;
        send_request(x);
        x.client_addr = '0; x.tie_bits = 8'h00; send_request(x);
        send_request(x);
        set_policy(POL_RR);
        repeat (10) send_request(x);
        x.service = 4'd3; send_request(x);
        set_policy(POL_STATIC);
        x.service = 4'd15; send_request(x);
        x.service = 4'd3; send_request(x);
        x.client_addr = 32'h1234_5678; x.service = 4'd15; send_request(x);
    endtask

    task automatic test_saturation();
        in_t x;
        set_policy(POL_STATIC);
        x = '0; x.service = 4'd9; x.cmd = CMD_UPDATE; x.instance_addr = 32'h0900_0009;
        send_request(x);
        x.cmd = CMD_REQUEST; x.client_addr = 32'h0900_1111; send_request(x);
        iload_m[9*MAX_INSTANCES] = iload_m[9*MAX_INSTANCES];
        repeat (20) send_request(x);
    endtask

    task automatic test_random(int items, logic [1:0] p, int idle);
        int svc;
        set_policy(p);
        idle_pct = idle;
        for (int i = 0; i < items; i++) begin
            svc = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(3);
            send_request(rand_item($urandom_range(99) < 35, svc));
        end
    endtask

    task automatic test_affinity_full();
        in_t x;
        set_policy(POL_SHORTEST);
        idle_pct = 0;
        x = '0;
        for (int i = 0; i < 70; i++) begin
            x.client_addr = 32'hAB00_0000 + i; x.service = 4'd0; send_request(x);
        end
        set_policy(POL_STATIC);
        x.client_addr = 32'hAB00_0045; send_request(x);
        x.client_addr = 32'hAB00_0001; send_request(x);
    endtask

    always @(posedge clk) begin
        out_t e;
        if (rst_n && result_valid) begin
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, result);
                failed = 1'b1;
            end else begin
                e = pending_q.pop_front();
                if (result !== e) begin
                    $display("%0t mismatch expected %h actual %h", $time, e, result);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        pol_m = POL_SHORTEST;
        fill_m = 0;
        for (int i = 0; i < SERVICES; i++) begin
            cnt_m[i] = 0; rrpos_m[i] = 0; rrseen_m[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++) addr_pool[i] = $urandom();
        for (int i = 0; i < 80; i++) client_pool[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_random(200, POL_SHORTEST, 0);
        test_random(200, POL_RR, 74);
        test_random(200, POL_STATIC, 14);
        test_random(180, POL_SPARE, 0);
        test_affinity_full();
        test_random(100, POL_STATIC, 74);
        test_random(50, POL_RR, 14);
        set_policy(POL_SHORTEST);
        drain();
        if (!failed && pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/silb_pkg.sv
hw/rtl/silb_ram.sv
hw/rtl/silb_ctrl.sv
hw/rtl/silb_dp.sv
hw/rtl/server_instance_load_balancer_top.sv
test/tb.sv
